### design/u8san_pkg.sv
// Shared types and constants for the UTF-8 stream sanitizer.
package u8san_pkg;

    localparam int          QUEUE_DEPTH = 4;
    localparam int          HOLD_DEPTH  = 3;
    localparam int          SLOTS       = 4;
    localparam logic [7:0]  REPL_BYTE   = 8'h3F;

    // One group of output beats produced by a single input beat.
    typedef struct packed {
        logic [SLOTS-1:0][7:0] bytes;
        logic [SLOTS-1:0]      repl;
        logic [1:0]            last_slot;
        logic                  last;
    } group_t;

endpackage

### design/u8san_front.sv
// Front end: classifies input beats, tracks open sequences, builds output groups.
module u8san_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    output logic                push,
    output u8san_pkg::group_t   group
);

    logic [u8san_pkg::HOLD_DEPTH-1:0][7:0] held_reg, held_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] need_reg, need_next;

    logic       accept;
    logic       held, is_cont, is_lead, is_ascii;
    logic [1:0] lead_need;
    logic       append, flush, emit_b, hold_lead;
    logic       h_repl, b_repl;
    logic [1:0] hc_eff;
    logic [2:0] count;

    always_comb
    begin
        accept   = in_valid && in_ready;
        held     = (cnt_reg != 2'd0);
        is_ascii = (in_byte[7] == 1'b0);
        is_cont  = ((in_byte & 8'hC0) == 8'h80);
        lead_need = 2'd0;
        is_lead   = 1'b1;
        if ((in_byte & 8'hE0) == 8'hC0)
            lead_need = 2'd1;
        else if ((in_byte & 8'hF0) == 8'hE0)
            lead_need = 2'd2;
        else if ((in_byte & 8'hF8) == 8'hF0)
            lead_need = 2'd3;
        else
            is_lead = 1'b0;

        append = held && is_cont && (need_reg > 2'd1) && (cnt_reg < 2'd3);
        flush  = held && !(append && !in_last);
        h_repl = !(is_cont && (need_reg <= 2'd1));
        if (held && is_cont)
        begin
            emit_b = flush;
            b_repl = h_repl;
        end
        else
        begin
            emit_b = !(is_lead && !in_last);
            b_repl = !is_ascii;
        end
        hold_lead = !(held && is_cont) && is_lead && !in_last;

        hc_eff = flush ? cnt_reg : 2'd0;
        count  = {1'b0, hc_eff} + {2'b00, emit_b};
    end

    always_comb
    begin
        for (int i = 0; i < u8san_pkg::HOLD_DEPTH; i++)
        begin
            if (2'(i) < hc_eff)
            begin
                group.bytes[i] = held_reg[i];
                group.repl[i]  = h_repl;
            end
            else
            begin
                group.bytes[i] = in_byte;
                group.repl[i]  = b_repl;
            end
        end
        group.bytes[u8san_pkg::SLOTS-1] = in_byte;
        group.repl[u8san_pkg::SLOTS-1]  = b_repl;
        for (int i = 0; i < u8san_pkg::SLOTS; i++)
        begin
            if (group.repl[i])
                group.bytes[i] = u8san_pkg::REPL_BYTE;
        end
        group.last_slot = 2'(count - 3'd1);
        group.last      = in_last;
        push            = accept && (count != 3'd0);
    end

    always_comb
    begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        need_next = need_reg;
        if (accept)
        begin
            if (in_last)
            begin
                cnt_next  = 2'd0;
                need_next = 2'd0;
            end
            else if (append)
            begin
                for (int i = 0; i < u8san_pkg::HOLD_DEPTH; i++)
                begin
                    if (2'(i) == cnt_reg)
                        held_next[i] = in_byte;
                end
                cnt_next  = cnt_reg + 2'd1;
                need_next = need_reg - 2'd1;
            end
            else if (hold_lead)
            begin
                held_next[0] = in_byte;
                cnt_next     = 2'd1;
                need_next    = lead_need;
            end
            else
            begin
                cnt_next  = 2'd0;
                need_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            need_reg <= 2'd0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            need_reg <= need_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

endmodule

### design/u8san_queue.sv
// Small FIFO of output groups between front end and back end.
module u8san_queue
#(
    parameter int DEPTH = u8san_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  u8san_pkg::group_t   push_data,
    input  logic                pop,
    output u8san_pkg::group_t   head,
    output logic                empty,
    output logic                full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8san_pkg::group_t entry_reg [DEPTH];
    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          do_push, do_pop;

    always_comb
    begin
        empty   = (fill_reg == CW'(0));
        full    = (fill_reg == CW'(DEPTH));
        do_push = push && !full;
        do_pop  = pop && !empty;
        head    = entry_reg[rd_reg];
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (do_push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_reg + PW'(1);
        if (do_pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_reg + PW'(1);
        fill_next = fill_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_reg] <= push_data;
    end

endmodule

### design/u8san_back.sv
// Back end: walks the head group and sends one beat per byte.
module u8san_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  u8san_pkg::group_t   head,
    input  logic                empty,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                was_replaced,
    output logic                run_last,
    output logic                stream_last
);

    logic [1:0] idx_reg, idx_next;
    logic       fire;

    always_comb
    begin
        out_valid    = !empty;
        out_byte     = head.bytes[idx_reg];
        was_replaced = head.repl[idx_reg];
        run_last     = (idx_reg == head.last_slot);
        stream_last  = run_last && head.last;
        fire         = out_valid && out_ready;
        pop          = fire && run_last;
        idx_next     = idx_reg;
        if (fire)
            idx_next = run_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 2'd0;
        else
            idx_reg <= idx_next;
    end

endmodule

### design/utf8_stream_sanitizer_unit.sv
// Top level of the UTF-8 stream sanitizer.
// Takes one byte per beat and returns one byte per beat, each passed through or
// replaced by '?'. A byte is accepted every cycle while the group queue
// (QUEUE_DEPTH entries) has room. Bytes of an open multibyte sequence are held
// until it completes or breaks, then leave as a burst of up to four beats, one
// per cycle while out_ready is high; the queue absorbs input meanwhile.
// in_ready drops only when the queue is full.
module utf8_stream_sanitizer_unit
#(
    parameter int QUEUE_DEPTH = u8san_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        was_replaced,
    output logic        run_last,
    output logic        stream_last
);

    u8san_pkg::group_t group, head;
    logic              push, pop, empty, full;

    assign in_ready = !full;

    u8san_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .push     (push),
        .group    (group)
    );

    u8san_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (group),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    u8san_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .was_replaced (was_replaced),
        .run_last     (run_last),
        .stream_last  (stream_last)
    );

endmodule

### test/tb_u8san_pkg.sv
`timescale 1ns / 100ps
// Byte-stream predictor and scoreboard used by the UTF-8 sanitizer testbench.
package tb_u8san_pkg;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam int         MAX_PRINTS = 30;

    typedef struct packed {
        logic [7:0] data;
        logic       repl;
        logic       run_end;
        logic       stream_end;
    } san_beat_t;

    class utf8_scoreboard;
        san_beat_t   due_q[$];
        san_beat_t   step_q[$];
        logic [7:0]  held_bytes [3];
        int unsigned held_cnt;
        int unsigned need_cnt;
        int unsigned errors;
        int unsigned items;
        int unsigned beats;
        int unsigned replaced;
        int unsigned streams;

        function new();
            clear_held();
            errors   = 0;
            items    = 0;
            beats    = 0;
            replaced = 0;
            streams  = 0;
        endfunction

        function void clear_held();
            for (int i = 0; i < 3; i++)
            begin
                held_bytes[i] = 8'h00;
            end
            held_cnt = 0;
            need_cnt = 0;
        endfunction

        function void emit(logic [7:0] b, logic repl);
            san_beat_t beat;
            beat.data       = repl ? u8san_pkg::REPL_BYTE : b;
            beat.repl       = repl;
            beat.run_end    = 1'b0;
            beat.stream_end = 1'b0;
            step_q.push_back(beat);
        endfunction

        function void flush_held(logic repl);
            for (int i = 0; i < held_cnt; i++)
            begin
                emit(held_bytes[i], repl);
            end
            clear_held();
        endfunction

        // byte seen with nothing held
        function void start_byte(logic [7:0] b, logic last);
            int unsigned need;
            need = 0;
            if (!b[7])
            begin
                emit(b, 1'b0);
                return;
            end
            if ((b & LEAD2_MASK) == LEAD2_TAG)
                need = 1;
            else if ((b & LEAD3_MASK) == LEAD3_TAG)
                need = 2;
            else if ((b & LEAD4_MASK) == LEAD4_TAG)
                need = 3;
            if (need == 0 || last)
            begin
                emit(b, 1'b1);
                return;
            end
            held_bytes[0] = b;
            held_cnt      = 1;
            need_cnt      = need;
        endfunction

        function void note_input(logic [7:0] b, logic last);
            step_q.delete();
            items++;
            if (held_cnt > 0)
            begin
                if ((b & CONT_MASK) == CONT_TAG)
                begin
                    if (need_cnt <= 1)
                    begin
                        flush_held(1'b0);
                        emit(b, 1'b0);
                    end
                    else if (last || held_cnt >= 3)
                    begin
                        flush_held(1'b1);
                        emit(b, 1'b1);
                    end
                    else
                    begin
                        held_bytes[held_cnt] = b;
                        held_cnt++;
                        need_cnt--;
                    end
                end
                else
                begin
                    flush_held(1'b1);
                    start_byte(b, last);
                end
            end
            else
            begin
                start_byte(b, last);
            end
            if (step_q.size() > 0)
            begin
                step_q[step_q.size() - 1].run_end    = 1'b1;
                step_q[step_q.size() - 1].stream_end = last;
            end
            if (last)
            begin
                clear_held();
                streams++;
            end
            foreach (step_q[i])
            begin
                if (step_q[i].repl)
                    replaced++;
                due_q.push_back(step_q[i]);
            end
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("ERROR at %0t: %s", $realtime, msg);
        endtask

        task check_beat(logic [7:0] data, logic repl, logic run_end, logic stream_end);
            san_beat_t want;
            beats++;
            if (due_q.size() == 0)
            begin
                report($sformatf("output beat %0d byte=%02h arrived with none due", beats, data));
                return;
            end
            want = due_q.pop_front();
            if (data !== want.data || repl !== want.repl || run_end !== want.run_end
                || stream_end !== want.stream_end)
                report($sformatf({"beat %0d: byte=%02h/%02h repl=%b/%b run_last=%b/%b ",
                                  "stream_last=%b/%b (got/want)"},
                                 beats, data, want.data, repl, want.repl,
                                 run_end, want.run_end, stream_end, want.stream_end));
        endtask
    endclass

endpackage

### test/tb_utf8_stream_sanitizer_unit.sv
`timescale 1ns / 100ps
// Top testbench: directed and random byte streams with random stalls on both sides.
module tb_utf8_stream_sanitizer_unit;

    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_AT_BEAT  = 150;
    localparam int HOLD_CYCLES   = 120;
    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_item_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       in_last;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       run_last;
    logic       stream_last;

    stream_item_t                  stim_q[$];
    tb_u8san_pkg::utf8_scoreboard  sb;

    utf8_stream_sanitizer_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .in_last      (in_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .was_replaced (was_replaced),
        .run_last     (run_last),
        .stream_last  (stream_last)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function void add_byte(logic [7:0] b, logic last);
        stream_item_t it;
        it.data = b;
        it.last = last;
        stim_q.push_back(it);
    endfunction

    function logic draw_last();
        return ($urandom_range(0, 39) == 0);
    endfunction

    // mostly well-formed sequences, some truncated ones and junk
    function void add_random_segment();
        int unsigned kind;
        int unsigned need;
        int unsigned conts;
        logic [7:0]  lead;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            add_byte(8'($urandom_range(8'h00, 8'h7F)), draw_last());
        end
        else if (kind < 80)
        begin
            need = $urandom_range(1, 3);
            case (need)
                1:       lead = 8'($urandom_range(8'hC0, 8'hDF));
                2:       lead = 8'($urandom_range(8'hE0, 8'hEF));
                default: lead = 8'($urandom_range(8'hF0, 8'hF7));
            endcase
            conts = (kind < 70) ? need : $urandom_range(0, need - 1);
            add_byte(lead, draw_last());
            for (int i = 0; i < conts; i++)
            begin
                add_byte(8'($urandom_range(8'h80, 8'hBF)), draw_last());
            end
        end
        else if (kind < 88)
        begin
            add_byte(8'($urandom_range(8'h80, 8'hBF)), draw_last());
        end
        else if (kind < 94)
        begin
            add_byte(8'($urandom_range(8'hF8, 8'hFF)), draw_last());
        end
        else
        begin
            add_byte(8'($urandom), draw_last());
        end
    endfunction

    task send_item(stream_item_t it);
        in_valid <= 1'b1;
        in_byte  <= it.data;
        in_last  <= it.last;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(it.data, it.last);
    endtask

    task take_beat();
        out_ready <= 1'b1;
        do
            @(posedge clk);
        while (!out_valid);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_beat(out_byte, was_replaced, run_last, stream_last);
    end

    // receiver: random stalls, gapless stretches, one long hold-off
    initial
    begin
        int unsigned gap;
        int unsigned taken;
        bit          steady;
        bit          held_off;
        out_ready <= 1'b0;
        taken    = 0;
        steady   = 1'b0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 60 == 0)
                steady = $urandom_range(0, 1);
            if (!held_off && taken == HOLD_AT_BEAT)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = steady ? 0 : $urandom_range(0, 10);
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            take_beat();
            taken++;
        end
    end

    initial
    begin
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int unsigned gap;
        int unsigned directed;
        bit          steady;
        sb = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_byte  <= 8'h00;
        in_last  <= 1'b0;

        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        add_byte(8'hC3, 1'b0);
        add_byte(8'hA9, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hAC, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h9F, 1'b0);
        add_byte(8'h98, 1'b0);
        add_byte(8'h80, 1'b0);
        // stray continuations, invalid leads
        add_byte(8'h80, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hF8, 1'b0);
        add_byte(8'hFF, 1'b0);
        // broken by ascii, then broken by a new lead that completes
        add_byte(8'hC3, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b0);
        add_byte(8'hF4, 1'b0);
        add_byte(8'h90, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hBF, 1'b0);
        // stream ends on a lead, on a short sequence, on plain ascii
        add_byte(8'hC3, 1'b1);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b1);
        add_byte(8'h41, 1'b1);
        directed = stim_q.size();
        while (stim_q.size() < directed + RANDOM_ITEMS)
            add_random_segment();
        stim_q[stim_q.size() - 1].last = 1'b1;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        steady = 1'b0;
        foreach (stim_q[i])
        begin
            if (i % 40 == 0)
                steady = $urandom_range(0, 1);
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            send_item(stim_q[i]);
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display({"Sent %0d bytes (%0d directed) in %0d streams; ",
                  "checked %0d output beats, %0d replaced."},
                 sb.items, directed, sb.streams, sb.beats, sb.replaced);
        $display("Receiver held off %0d cycles once to back up the input; %0d mismatches.",
                 HOLD_CYCLES, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
